// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, payload types, command codes and sequencer states for the
// text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int CELL_COUNT     = COLUMNS * ROWS;
    localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;

    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ADDR_W = 11;
    localparam int CUR_W  = 11;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SHIFT,
        S_BLANK,
        S_CLEAR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] character;
        logic [ADDR_W-1:0] cell_index;
    } t_item;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic [ATTR_W-1:0] read_attr;
        logic [CUR_W-1:0]  cursor_pos;
        logic              scrolled;
    } t_result;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] character;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] character;
    } t_cell;

endpackage

// ===== src/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer
// 80 x 25 text console: a cell memory of character and attribute bytes with
// a linear cursor, driven by put, read and clear commands.
// ----------------------------------------------------------------------------
// A put or unused command completes in the idle state, and a read returns its
// result from the finishing state. A scroll (newline on the last row, or any
// character on a full screen) and a clear both walk the cell memory one cell
// per cycle. After reset a clearing pass zeroes the memory; input items are
// not taken during it, configuration writes are. A two-entry command queue
// lets input transfers continue while a long command runs, and the registered
// result lets a read, scroll or clear start while the previous result waits
// for its transfer.
module text_console_cell_writer
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_item             i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ATTR_W-1:0] i_cfg_data
);

    logic [ATTR_W-1:0] r_attr;
    logic              push;
    t_entry            push_entry;
    logic              q_full;
    logic              q_valid;
    t_entry            q_entry;
    logic              pop;
    logic              busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    tcw_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (i_in_data),
        .i_full     (q_full),
        .i_busy     (busy),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .o_full  (q_full)
    );

    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      (r_attr),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input items and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
(
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_item  i_item,
    input  logic   i_full,
    input  logic   i_busy,
    output logic   o_push,
    output t_entry o_entry
);

    always_comb begin
        o_entry.character = i_item.character;
        o_entry.addr      = i_item.cell_index;
        o_entry.op        = OP_NOP;
        case (i_item.kind)
            KIND_PUT: begin
                o_entry.op = (i_item.character == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
            end
            KIND_READ: begin
                // out of range reads return zeros like the unused kind
                if (i_item.cell_index < ADDR_W'(CELL_COUNT)) begin
                    o_entry.op = OP_READ;
                end
            end
            KIND_CLEAR: begin
                o_entry.op = OP_CLEAR;
            end
            default: begin
                o_entry.op = OP_NOP;
            end
        endcase
    end

    assign o_in_ready = !i_full && !i_busy;
    assign o_push     = i_in_valid && o_in_ready;

endmodule

// ===== src/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tcw_queue
    import tcw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry,
    output logic   o_full
);

    t_entry            r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr] <= i_entry;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_entry = r_slots[r_rd];

endmodule

// ===== src/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Executes console commands against the cell memory and the cursor, walks
// the memory for scroll, clear and the post-reset clearing pass.
// ----------------------------------------------------------------------------
module tcw_back
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ATTR_W-1:0] i_attr,
    input  logic              i_q_valid,
    input  t_entry            i_q_entry,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_out_data
);

    t_cell r_mem [CELL_COUNT];

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_wptr, n_wptr;
    logic              r_pend, n_pend;
    logic [CUR_W-1:0]  r_cur, n_cur;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    t_op               r_op, n_op;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    t_cell             r_rdata;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_cell             mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              out_free;
    logic              out_load;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_wptr    = r_wptr;
        n_pend    = 1'b0;
        n_cur     = r_cur;
        n_row     = r_row;
        n_col     = r_col;
        n_op      = r_op;
        n_char    = r_char;
        n_out     = r_out;
        out_load  = 1'b0;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = i_q_entry.addr;

        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_entry.op)
                        OP_PUT: begin
                            if (r_row == ROW_W'(ROWS)) begin
                                o_pop   = 1'b1;
                                n_op    = i_q_entry.op;
                                n_char  = i_q_entry.character;
                                n_ptr   = '0;
                                n_state = S_SHIFT;
                            end else if (out_free) begin
                                o_pop     = 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = r_cur;
                                mem_wdata = {i_attr, i_q_entry.character};
                                n_cur     = r_cur + 1'b1;
                                if (r_col == COL_W'(COLUMNS - 1)) begin
                                    n_col = '0;
                                    n_row = r_row + 1'b1;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                                out_load = 1'b1;
                                n_out    = '{read_char: '0, read_attr: '0,
                                             cursor_pos: r_cur + 1'b1, scrolled: 1'b0};
                            end
                        end
                        OP_NEWLINE: begin
                            if (r_row >= ROW_W'(ROWS - 1)) begin
                                o_pop   = 1'b1;
                                n_op    = i_q_entry.op;
                                n_char  = i_q_entry.character;
                                n_ptr   = '0;
                                n_state = S_SHIFT;
                            end else if (out_free) begin
                                o_pop    = 1'b1;
                                n_cur    = r_cur + CUR_W'(COLUMNS) - CUR_W'(r_col);
                                n_col    = '0;
                                n_row    = r_row + 1'b1;
                                out_load = 1'b1;
                                n_out    = '{read_char: '0, read_attr: '0,
                                             cursor_pos: r_cur + CUR_W'(COLUMNS) - CUR_W'(r_col),
                                             scrolled: 1'b0};
                            end
                        end
                        OP_READ: begin
                            o_pop     = 1'b1;
                            mem_re    = 1'b1;
                            mem_raddr = i_q_entry.addr;
                            n_op      = i_q_entry.op;
                            n_state   = S_FIN;
                        end
                        OP_CLEAR: begin
                            o_pop   = 1'b1;
                            n_op    = i_q_entry.op;
                            n_ptr   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            if (out_free) begin
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                                n_out    = '{read_char: '0, read_attr: '0,
                                             cursor_pos: r_cur, scrolled: 1'b0};
                            end
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // read one row ahead, write the previous read in the next cycle
                mem_re    = 1'b1;
                mem_raddr = r_ptr + ADDR_W'(COLUMNS);
                n_pend    = 1'b1;
                n_wptr    = r_ptr;
                mem_we    = r_pend;
                mem_waddr = r_wptr;
                mem_wdata = r_rdata;
                if (r_ptr == ADDR_W'(LAST_ROW_START - 1)) begin
                    n_ptr   = ADDR_W'(LAST_ROW_START);
                    n_state = S_BLANK;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_BLANK: begin
                mem_we = 1'b1;
                if (r_pend) begin
                    mem_waddr = r_wptr;
                    mem_wdata = r_rdata;
                end else begin
                    mem_waddr = r_ptr;
                    mem_wdata = {i_attr, CHAR_W'(0)};
                    if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    case (r_op)
                        OP_READ: begin
                            n_out = '{read_char: r_rdata.character, read_attr: r_rdata.attr,
                                      cursor_pos: r_cur, scrolled: 1'b0};
                        end
                        OP_CLEAR: begin
                            n_cur = '0;
                            n_row = '0;
                            n_col = '0;
                            n_out = '{read_char: '0, read_attr: '0,
                                      cursor_pos: '0, scrolled: 1'b0};
                        end
                        OP_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = ADDR_W'(LAST_ROW_START);
                            mem_wdata = {i_attr, r_char};
                            n_cur     = CUR_W'(LAST_ROW_START + 1);
                            n_row     = ROW_W'(ROWS - 1);
                            n_col     = COL_W'(1);
                            n_out     = '{read_char: '0, read_attr: '0,
                                          cursor_pos: CUR_W'(LAST_ROW_START + 1),
                                          scrolled: 1'b1};
                        end
                        OP_NEWLINE: begin
                            n_cur = CUR_W'(LAST_ROW_START);
                            n_row = ROW_W'(ROWS - 1);
                            n_col = '0;
                            n_out = '{read_char: '0, read_attr: '0,
                                      cursor_pos: CUR_W'(LAST_ROW_START), scrolled: 1'b1};
                        end
                        default: begin
                            n_out = '{read_char: '0, read_attr: '0,
                                      cursor_pos: r_cur, scrolled: 1'b0};
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_cur       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_cur       <= n_cur;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wptr <= n_wptr;
        r_op   <= n_op;
        r_char <= n_char;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign o_busy      = (r_state == S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= CUR_W'(CELL_COUNT))
        else $error("cursor beyond screen");

    a_cursor_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cur) == int'(r_row) * COLUMNS + int'(r_col))
        else $error("cursor row and column out of step");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE)
        else $error("queue popped outside idle");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.scrolled |->
            r_out.cursor_pos == CUR_W'(LAST_ROW_START) ||
            r_out.cursor_pos == CUR_W'(LAST_ROW_START + 1))
        else $error("scroll result with wrong cursor");

    a_reset_init: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == S_INIT)
        else $error("reset did not start clearing pass");
`endif

endmodule

// ===== tb/text_console_cell_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer_tb
// Self-checking bench for the text console cell writer. A scoreboard keeps
// its own copy of the cell store, cursor and attribute, predicts the result
// of every accepted command and checks each result transfer in order. A short
// directed run covers field extremes, newline walks and a last-row scroll;
// random phases then mix puts, reads, clears and the unused kind under
// different sender and receiver idling, with attribute writes in between.
// ----------------------------------------------------------------------------
module text_console_cell_writer_tb
    import tcw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SLOW_OP_BUDGET = 250;
    localparam int PHASE_ITEMS    = 478;
    localparam int SETTLE_CYCLES  = 2100;

    class console_scoreboard;
        t_cell             cells [CELL_COUNT];
        int unsigned       cursor;
        logic [ATTR_W-1:0] attr;
        t_result           expected_q [$];
        int unsigned       errors;
        int unsigned       slow_ops;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cursor   = 0;
            attr     = ATTR_RESET;
            errors   = 0;
            slow_ops = 0;
        endfunction

        function void set_attr(logic [ATTR_W-1:0] value);
            attr = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void scroll_rows();
            for (int i = 0; i < LAST_ROW_START; i++) cells[i] = cells[i + COLUMNS];
            for (int k = 0; k < COLUMNS; k++) cells[LAST_ROW_START + k] = {attr, 8'h00};
        endfunction

        function void note_input(t_item it);
            t_result r;
            logic    is_newline;
            r = '0;
            is_newline = (it.character == NEWLINE_CODE);
            case (it.kind)
                KIND_PUT: begin
                    if (cursor >= CELL_COUNT || (cursor >= LAST_ROW_START && is_newline)) begin
                        scroll_rows();
                        r.scrolled = 1'b1;
                        cursor = LAST_ROW_START;
                        slow_ops++;
                        if (!is_newline) begin
                            cells[cursor] = {attr, it.character};
                            cursor++;
                        end
                    end else if (is_newline) begin
                        cursor += COLUMNS - (cursor % COLUMNS);
                    end else begin
                        cells[cursor] = {attr, it.character};
                        cursor++;
                    end
                end
                KIND_READ: begin
                    if (it.cell_index < CELL_COUNT) begin
                        r.read_char = cells[it.cell_index].character;
                        r.read_attr = cells[it.cell_index].attr;
                    end
                end
                KIND_CLEAR: begin
                    foreach (cells[i]) cells[i] = '0;
                    cursor = 0;
                    slow_ops++;
                end
                default: ;
            endcase
            r.cursor_pos = CUR_W'(cursor);
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected: %p", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.read_char !== want.read_char) begin
                $error("read_char expected %0d actual %0d", want.read_char, got.read_char);
                errors++;
            end
            if (got.read_attr !== want.read_attr) begin
                $error("read_attr expected %0d actual %0d", want.read_attr, got.read_attr);
                errors++;
            end
            if (got.cursor_pos !== want.cursor_pos) begin
                $error("cursor_pos expected %0d actual %0d", want.cursor_pos, got.cursor_pos);
                errors++;
            end
            if (got.scrolled !== want.scrolled) begin
                $error("scrolled expected %0d actual %0d", want.scrolled, got.scrolled);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_item             in_data   = '0;
    logic              out_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [ATTR_W-1:0] cfg_data  = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    t_result           o_out_data;
    logic              o_cfg_ready;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    console_scoreboard sb = new();

    text_console_cell_writer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) sb.check_result(o_out_data);
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input t_item it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                            input logic [ADDR_W-1:0] idx);
        t_item it;
        it.kind       = kind;
        it.character  = ch;
        it.cell_index = idx;
        send_item(it);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        sb.set_attr(value);
    endtask

    task automatic wait_for_results();
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic t_item random_item();
        t_item       it;
        int unsigned pick;
        logic        scroll_now;
        it.character  = CHAR_W'($urandom);
        it.cell_index = ADDR_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 3) it.kind = KIND_UNUSED;
        else if (pick < 4) it.kind = KIND_CLEAR;
        else if (pick < 40) it.kind = KIND_READ;
        else it.kind = KIND_PUT;
        if (it.kind == KIND_PUT && $urandom_range(99) < 20) it.character = NEWLINE_CODE;
        if (it.kind == KIND_READ && $urandom_range(9) != 0)
            it.cell_index = ADDR_W'($urandom_range(CELL_COUNT - 1));
        // scrolls and clears walk the whole store, so keep them rationed
        scroll_now = (it.kind == KIND_PUT) && (sb.cursor >= CELL_COUNT ||
                     (sb.cursor >= LAST_ROW_START && it.character == NEWLINE_CODE));
        if (scroll_now && (sb.slow_ops >= SLOW_OP_BUDGET || $urandom_range(99) >= 25))
            it.kind = KIND_READ;
        if (it.kind == KIND_CLEAR && sb.slow_ops >= SLOW_OP_BUDGET) it.kind = KIND_READ;
        return it;
    endfunction

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input logic [ATTR_W-1:0] attr_value);
        wait_for_results();
        write_attr(attr_value);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
        in_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        // reset contents, in-range and out-of-range reads
        send_cmd(KIND_READ, 8'h00, 11'd1999);
        send_cmd(KIND_READ, 8'hFF, 11'h7FF);
        send_cmd(KIND_PUT, 8'h41, 11'h000);
        send_cmd(KIND_PUT, 8'hFF, 11'h7FF);
        send_cmd(KIND_PUT, 8'h00, 11'h000);
        send_cmd(KIND_READ, 8'h00, 11'd1);
        send_cmd(KIND_UNUSED, 8'hFF, 11'h7FF);
        in_valid <= 1'b0;

        wait_for_results();
        write_attr(8'hFF);
        // walk down to the last row, then scroll on a newline
        for (int r = 0; r < ROWS; r++) send_cmd(KIND_PUT, NEWLINE_CODE, 11'h000);
        send_cmd(KIND_PUT, 8'h5A, 11'h000);
        send_cmd(KIND_READ, 8'h00, 11'd0);
        send_cmd(KIND_READ, 8'h00, 11'(LAST_ROW_START + 1));
        send_cmd(KIND_CLEAR, 8'h00, 11'h000);
        send_cmd(KIND_READ, 8'h00, 11'(LAST_ROW_START + 1));
        in_valid <= 1'b0;

        run_phase(0, 0, 8'h00);
        run_phase(72, 0, 8'($urandom));
        run_phase(0, 72, 8'hFF);
        run_phase(15, 15, 8'($urandom));

        recv_stall_pct = 0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
